// ===== rtl/core/skf_pkg.sv =====
// Shared types, constants and microcode table of the scalar Kalman filter.
package skf_pkg;

    // Q16.16 data formats
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = FRAC_W + 1;
    localparam int DENOM_W  = DATA_W + 1;
    localparam int INNOV_W  = DATA_W + 1;
    localparam int MULB_W   = INNOV_W + 1;
    localparam int PROD_W   = GAIN_W + MULB_W;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);
    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'h0001_0000;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'h07D0_0000;

    // Sequencer sizes: the divide step runs once per quotient bit
    localparam int PC_W     = 3;
    localparam int CNT_W    = 5;
    localparam logic [CNT_W-1:0] DIV_CNT_START = CNT_W'(GAIN_W - 1);

    // Step addresses
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_PRED = 3'd1;
    localparam logic [PC_W-1:0] PC_DEN  = 3'd2;
    localparam logic [PC_W-1:0] PC_DIV  = 3'd3;
    localparam logic [PC_W-1:0] PC_GAIN = 3'd4;
    localparam logic [PC_W-1:0] PC_MUL  = 3'd5;
    localparam logic [PC_W-1:0] PC_EST  = 3'd6;
    localparam logic [PC_W-1:0] PC_COV  = 3'd7;

    // Hold conditions of a step
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_INPUT,
        STALL_OUTPUT
    } skf_stall_t;

    // Branch kinds of a step
    typedef enum logic [1:0] {
        BR_NEXT,
        BR_LOOP,
        BR_JUMP
    } skf_br_t;

    // Datapath actions of one step
    typedef struct packed {
        logic ld_meas;
        logic ld_pred;
        logic ld_den;
        logic cnt_load;
        logic div_step;
        logic ld_gain;
        logic ld_prod;
        logic mul_cov;
        logic ld_est;
        logic ld_cov;
        logic emit;
    } skf_act_t;

    // One control word
    typedef struct packed {
        skf_stall_t      stall;
        skf_br_t         br;
        logic [PC_W-1:0] target;
        skf_act_t        act;
    } skf_uword_t;

    // Status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } skf_stat_t;

    // Microcode ROM
    function automatic skf_uword_t skf_ucode(input logic [PC_W-1:0] pc);
        skf_uword_t w;
        w = '0;
        w.stall  = STALL_NONE;
        w.br     = BR_NEXT;
        w.target = PC_IDLE;
        unique case (pc)
            PC_IDLE:
            begin
                w.stall       = STALL_INPUT;
                w.act.ld_meas = 1'b1;
            end
            PC_PRED:
            begin
                w.act.ld_pred = 1'b1;
            end
            PC_DEN:
            begin
                w.act.ld_den   = 1'b1;
                w.act.cnt_load = 1'b1;
            end
            PC_DIV:
            begin
                w.br           = BR_LOOP;
                w.target       = PC_DIV;
                w.act.div_step = 1'b1;
            end
            PC_GAIN:
            begin
                w.act.ld_gain = 1'b1;
            end
            PC_MUL:
            begin
                w.act.ld_prod = 1'b1;
            end
            PC_EST:
            begin
                w.act.ld_est  = 1'b1;
                w.act.ld_prod = 1'b1;
                w.act.mul_cov = 1'b1;
            end
            PC_COV:
            begin
                w.stall      = STALL_OUTPUT;
                w.br         = BR_JUMP;
                w.target     = PC_IDLE;
                w.act.ld_cov = 1'b1;
                w.act.emit   = 1'b1;
            end
            default:
            begin
                w.br     = BR_JUMP;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/skf_sequencer.sv =====
// Step counter, loop counter and microcode lookup of the Kalman filter.
module skf_sequencer
    import skf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  skf_stat_t stat,
    output logic      in_ready,
    output skf_act_t  act
);

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    skf_uword_t       uw;
    logic             stalled;

    // Control word of the current step
    assign uw = skf_ucode(pc_reg);

    // Hold decision
    always_comb
    begin
        unique case (uw.stall)
            STALL_NONE:   stalled = 1'b0;
            STALL_INPUT:  stalled = !stat.in_valid;
            STALL_OUTPUT: stalled = !stat.out_free;
            default:      stalled = 1'b0;
        endcase
    end

    assign in_ready = (uw.stall == STALL_INPUT);
    assign act      = stalled ? '0 : uw.act;

    // Next step
    always_comb
    begin
        pc_next = pc_reg;
        if (!stalled)
        begin
            unique case (uw.br)
                BR_NEXT: pc_next = pc_reg + PC_W'(1);
                BR_LOOP: pc_next = (cnt_reg != '0) ? uw.target : pc_reg + PC_W'(1);
                BR_JUMP: pc_next = uw.target;
                default: pc_next = PC_IDLE;
            endcase
        end
    end

    // Loop counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (uw.act.cnt_load && !stalled)
        begin
            cnt_next = DIV_CNT_START;
        end
        else if (uw.br == BR_LOOP && !stalled && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/skf_datapath.sv =====
// Registers, adder, divide step and shared multiplier of the Kalman filter.
module skf_datapath
    import skf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  skf_act_t          act,
    input  logic [DATA_W-1:0] meas_in,
    input  logic [DATA_W-1:0] q_noise,
    input  logic [DATA_W-1:0] r_noise,
    output logic [DATA_W-1:0] est
);

    logic [DATA_W-1:0]         est_reg, cov_reg, meas_reg, pred_reg;
    logic [DENOM_W-1:0]        denom_reg, rem_reg;
    logic [GAIN_W-1:0]         quo_reg, gain_reg;
    logic signed [INNOV_W-1:0] innov_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic [DATA_W:0]           pred_sum;
    logic [DENOM_W:0]          trial, diff;
    logic                      ge;
    logic [GAIN_W-1:0]         mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W:0]    mul_full;
    logic signed [DATA_W+3:0]  est_sum;

    // Predicted covariance, saturated
    assign pred_sum = {1'b0, cov_reg} + {1'b0, q_noise};

    // Restoring divide step: shift in the next dividend bit, compare, subtract
    assign trial = {rem_reg, quo_reg[GAIN_W-1]};
    assign diff  = trial - {1'b0, denom_reg};
    assign ge    = (trial >= {1'b0, denom_reg});

    // Shared multiplier: gain times innovation, then (1 - gain) times prediction
    assign mul_a    = act.mul_cov ? (GAIN_ONE - gain_reg) : gain_reg;
    assign mul_b    = act.mul_cov ? $signed({2'b00, pred_reg})
                                  : $signed({innov_reg[INNOV_W-1], innov_reg});
    assign mul_full = $signed({1'b0, mul_a}) * mul_b;

    // Estimate plus correction; the correction is the product floored by 2^16
    assign est_sum = $signed({{4{est_reg[DATA_W-1]}}, est_reg})
                   + $signed({prod_reg[PROD_W-1], prod_reg[PROD_W-1:FRAC_W]});

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            cov_reg <= '0;
        end
        else
        begin
            if (act.ld_est)
            begin
                if (est_sum > $signed((DATA_W+4)'(32'h7FFF_FFFF)))
                begin
                    est_reg <= 32'h7FFF_FFFF;
                end
                else if (est_sum < -$signed((DATA_W+4)'(33'h0_8000_0000)))
                begin
                    est_reg <= 32'h8000_0000;
                end
                else
                begin
                    est_reg <= est_sum[DATA_W-1:0];
                end
            end
            if (act.ld_cov)
            begin
                cov_reg <= prod_reg[DATA_W+FRAC_W-1:FRAC_W];
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (act.ld_meas)
        begin
            meas_reg <= meas_in;
        end
        if (act.ld_pred)
        begin
            pred_reg  <= pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
            innov_reg <= $signed({meas_reg[DATA_W-1], meas_reg})
                       - $signed({est_reg[DATA_W-1], est_reg});
        end
        if (act.ld_den)
        begin
            denom_reg <= {1'b0, pred_reg} + {1'b0, r_noise};
            rem_reg   <= {2'b00, pred_reg[DATA_W-1:1]};
            quo_reg   <= {pred_reg[0], {(GAIN_W-1){1'b0}}};
        end
        if (act.div_step)
        begin
            rem_reg <= ge ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
            quo_reg <= {quo_reg[GAIN_W-2:0], ge};
        end
        if (act.ld_gain)
        begin
            gain_reg <= (denom_reg == '0) ? GAIN_ONE : quo_reg;
        end
        if (act.ld_prod)
        begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
    end

    assign est = est_reg;

    // The gain never exceeds one.
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act.ld_gain |=> gain_reg <= GAIN_ONE)
        else $error("gain above 1.0");

    // The remainder stays below the divisor after each divide step.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act.div_step && denom_reg != '0 |=> rem_reg < denom_reg)
        else $error("divide remainder not reduced");

    // The covariance update never exceeds the predicted covariance.
    a_cov_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act.ld_cov |=> cov_reg <= $past(pred_reg))
        else $error("covariance grew in update");

endmodule

// ===== rtl/core/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: ports, configuration and result register.
//
//  channel  | direction | transaction carries
//  ---------+-----------+---------------------------------------------
//  s_*      | in        | tdata[31:0] measurement (signed Q16.16)
//  m_*      | out       | tdata[31:0] filtered_value (signed Q16.16)
//  cfg_*    | in        | cfg_index: 0 process_noise, 1 measure_noise
//
// A measurement is accepted in the idle step and its result is loaded at the last step,
// and no new measurement is taken until the sequence returns to idle; the 17 steps
// of the bit-serial gain divide make up most of that sequence.
// Reset sets Q to 1.0, R to 2000.0 and clears estimate and covariance.
// A new measurement is taken while the previous result waits on m_tready;
// the sequencer holds only at its last step if that result is still not taken.
// Configuration writes are taken at every cycle.
module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,    // [31:0] measurement
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,    // [31:0] filtered_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic [DATA_W-1:0] q_reg, r_reg, out_data_reg, est;
    logic              out_valid_reg;
    skf_act_t          act;
    skf_stat_t         stat;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= PROCESS_NOISE_RST;
            r_reg <= MEASURE_NOISE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROCESS_NOISE: q_reg <= cfg_data;
                REG_MEASURE_NOISE: r_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer status
    assign stat.in_valid = s_tvalid;
    assign stat.out_free = !out_valid_reg || m_tready;

    skf_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_ready (s_tready),
        .act      (act)
    );

    skf_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .act     (act),
        .meas_in (s_tdata),
        .q_noise (q_reg),
        .r_noise (r_reg),
        .est     (est)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.emit)
        begin
            out_data_reg <= est;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== test/skf_scoreboard.sv =====
// Scoreboard for the scalar Kalman filter: tracks the filter state and checks each output.
`timescale 1ns / 1ps

module skf_scoreboard
    import skf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [DATA_W-1:0]    m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   mismatch_count,
    output int                   pending_count,
    output int                   results_checked
);

    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;

    // Shadow copy of the filter state and noise settings.
    logic [DATA_W-1:0] q_noise;
    logic [DATA_W-1:0] r_noise;
    logic [DATA_W-1:0] est_q16;
    logic [DATA_W-1:0] cov_q16;

    // Filtered values still owed by the block, oldest first.
    logic [DATA_W-1:0] estimate_q[$];

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One predict/update pass of the filter on a new measurement.
    task automatic advance_filter(input logic [DATA_W-1:0] meas,
                                  output logic [DATA_W-1:0] new_est);
        logic [DATA_W:0]   cov_sum;
        logic [DATA_W-1:0] pred;
        logic [DATA_W:0]   denom;
        logic [63:0]       gain;
        logic [63:0]       cov_next;
        longint            innov;
        longint            corr;
        longint            next_val;
        cov_sum = {1'b0, cov_q16} + {1'b0, q_noise};
        pred = cov_sum[DATA_W] ? '1 : cov_sum[DATA_W-1:0];
        denom = {1'b0, pred} + {1'b0, r_noise};
        // A zero denominator forces a gain of exactly one.
        if (denom == '0)
        begin
            gain = 64'(GAIN_ONE);
        end
        else
        begin
            gain = {16'b0, pred, 16'b0} / {31'b0, denom};
        end
        if (gain > 64'(GAIN_ONE))
        begin
            gain = 64'(GAIN_ONE);
        end
        innov = longint'($signed(meas)) - longint'($signed(est_q16));
        corr = (longint'(gain) * innov) >>> FRAC_W;
        next_val = longint'($signed(est_q16)) + corr;
        if (next_val > EST_MAX)
        begin
            next_val = EST_MAX;
        end
        if (next_val < EST_MIN)
        begin
            next_val = EST_MIN;
        end
        est_q16 = next_val[DATA_W-1:0];
        cov_next = (64'(GAIN_ONE) - gain) * {32'b0, pred};
        cov_q16 = cov_next[DATA_W+FRAC_W-1:FRAC_W];
        new_est = est_q16;
    endtask

    // Watch all three channels at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic [DATA_W-1:0] want;
        if (!rst_n)
        begin
            q_noise = PROCESS_NOISE_RST;
            r_noise = MEASURE_NOISE_RST;
            est_q16 = '0;
            cov_q16 = '0;
            estimate_q.delete();
            pending_count = 0;
        end
        else
        begin
            // Register writes; other indexes are ignored by the block.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PROCESS_NOISE)
                begin
                    q_noise = cfg_data;
                end
                else if (cfg_index == REG_MEASURE_NOISE)
                begin
                    r_noise = cfg_data;
                end
            end
            // Output transaction: compare against the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                if (estimate_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected filtered_value %h with nothing pending",
                                              m_tdata));
                end
                else
                begin
                    want = estimate_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        report_mismatch($sformatf("result %0d: filtered_value got %h, wanted %h",
                                                  results_checked, m_tdata, want));
                    end
                    results_checked++;
                end
            end
            // Input transaction: run the filter and queue the new estimate.
            if (s_tvalid && s_tready)
            begin
                advance_filter(s_tdata, want);
                estimate_q.push_back(want);
            end
            pending_count = estimate_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the scalar Kalman filter testbench: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps

module testbench
    import skf_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
    localparam logic [DATA_W-1:0]    POS_FULL    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]    NEG_FULL    = 32'h8000_0000;
    localparam logic [DATA_W-1:0]    ALL_ONES    = 32'hFFFF_FFFF;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 150;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    int mismatch_count;
    int pending_count;
    int results_checked;
    int items_sent;
    int settings_run;
    bit idle_on;
    int idle_pct;
    int rx_hold;
    int rx_gap;

    scalar_kalman_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    skf_scoreboard scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(64'd20_000_000);
        $display("scalar_kalman_filter verification failed");
        $finish;
    end

    // Output side: random back-pressure bursts, plus a long hold on request.
    initial
    begin
        m_tready = 1'b0;
        rx_gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < idle_pct)
                begin
                    rx_gap = $urandom_range(1, 11);
                end
            end
        end
    end

    // Offer one measurement and hold it until the block takes it.
    task automatic send_measurement(input logic [DATA_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (idle_on && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // One register write transaction; the caller drops cfg_valid afterward.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Load both noise registers.
    task automatic set_noise(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r);
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASURE_NOISE, r);
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    // Stop offering input and wait until every filtered value has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Noise values spread over zero, full scale, small and arbitrary settings.
    function automatic logic [DATA_W-1:0] pick_noise;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return $urandom_range(0, 32'h0002_0000);
            3: return $urandom();
            4: return $urandom_range(32'h0001_0000, 32'h1000_0000);
            default: return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    // Mostly noisy readings around a level, with some full-range and extreme values.
    function automatic logic [DATA_W-1:0] pick_measurement(input logic [DATA_W-1:0] center);
        logic [DATA_W-1:0] span;
        int                roll;
        roll = $urandom_range(0, 99);
        span = 32'd1 << $urandom_range(4, 20);
        if (roll < 60)
        begin
            return center + $urandom_range(0, 2 * span) - span;
        end
        else if (roll < 85)
        begin
            return $urandom();
        end
        else if (roll < 95)
        begin
            case ($urandom_range(0, 3))
                0: return POS_FULL;
                1: return NEG_FULL;
                2: return '0;
                default: return ALL_ONES;
            endcase
        end
        return ~center;
    endfunction

    // Main stimulus.
    initial
    begin
        logic [DATA_W-1:0] center;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        settings_run = 1;
        idle_on = 1'b1;
        idle_pct = 20;
        rx_hold = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings with full-scale steps.
        send_measurement(POS_FULL);
        send_measurement(NEG_FULL);
        send_measurement('0);
        send_measurement(ALL_ONES);
        send_measurement(32'h0001_0000);
        send_measurement(POS_FULL);
        drain();

        // Zero noise on both sides: gain one, then a zero denominator.
        set_noise('0, '0);
        send_measurement(32'h1234_5678);
        send_measurement(NEG_FULL);
        send_measurement(POS_FULL);
        send_measurement(32'h0000_0001);
        drain();

        // Maximum noise: the predicted covariance saturates.
        set_noise(ALL_ONES, ALL_ONES);
        send_measurement(POS_FULL);
        send_measurement(NEG_FULL);
        send_measurement(POS_FULL);
        send_measurement(NEG_FULL);
        drain();

        set_noise(ALL_ONES, '0);
        send_measurement(NEG_FULL);
        send_measurement(POS_FULL);
        send_measurement('0);
        drain();

        // Writes to the spare indexes must leave the settings alone.
        set_noise(32'h0000_8000, 32'h0100_0000);
        write_reg(REG_SPARE_2, $urandom());
        write_reg(REG_SPARE_3, ALL_ONES);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_measurement(32'h0040_0000);
        send_measurement(32'hFFC0_0000);
        send_measurement(32'h0003_8000);
        drain();

        // Random phases, each under its own noise setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                set_noise(PROCESS_NOISE_RST, MEASURE_NOISE_RST);
            end
            else
            begin
                set_noise(pick_noise(), pick_noise());
            end
            idle_on = (phase != RANDOM_PHASES - 1);
            idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 15 : 40);
            center = $urandom();
            if (phase == 4)
            begin
                rx_hold = LONG_HOLD;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    center = $urandom();
                end
                send_measurement(pick_measurement(center));
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Summary: %0d measurements sent under %0d noise settings, %0d results checked.",
                 items_sent, settings_run, results_checked);
        $display("Covered zero and full-scale noise, saturated covariance and a long output stall.");
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("scalar_kalman_filter verification clean");
        end
        else
        begin
            $display("scalar_kalman_filter verification failed");
        end
        $finish;
    end

endmodule
